// ===== rtl/sobel_pkg.sv =====
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and fixed constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sobel_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // gray conversion weights, result is the weighted sum >> GRAY_SHIFT
    localparam logic [7:0] GRAY_KB    = 8'd30;
    localparam logic [7:0] GRAY_KG    = 8'd150;
    localparam logic [7:0] GRAY_KR    = 8'd76;
    localparam int         GRAY_SHIFT = 8;

    // gradient: difference of two 1-2-1 sums of 8-bit values
    localparam int         GRAD_W   = 11;
    localparam logic [7:0] EDGE_MAX = 8'd255;

    localparam int QUEUE_DEPTH = 4;

    // what one pixel word leaves for the back end to emit
    typedef struct packed {
        logic is_edge;   // centre has a full 3x3 neighbourhood
        logic last_col;  // pixel is in the rightmost column
        logic lrow;      // emit (c, r) as zero: last row
        logic rcol;      // emit (c, r-1) as zero: rightmost column
        logic centre;    // emit centre (c-1, r-1)
    } t_emit_ctl;

endpackage

// ===== rtl/sobel_fifo.sv =====
// ----------------------------------------------------------------------------
// sobel_fifo
// Short register queue between the front and the back end.
// ----------------------------------------------------------------------------
module sobel_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count;

    assign o_ready = (r_count != NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ===== rtl/sobel_front.sv =====
// ----------------------------------------------------------------------------
// sobel_front
// Pixel intake: gray conversion, line buffers, window and gradients.
// Classifies each pixel by the results it causes and queues them.
// ----------------------------------------------------------------------------
module sobel_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_blue,
    input  logic [7:0]                          i_green,
    input  logic [7:0]                          i_red,
    output logic                                o_push,
    input  logic                                i_q_ready,
    output sobel_pkg::t_emit_ctl                o_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]       o_row,
    output logic signed [sobel_pkg::GRAD_W-1:0] o_gx,
    output logic signed [sobel_pkg::GRAD_W-1:0] o_gy
);
    import sobel_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int EH = $clog2(MAX_HEIGHT + 1);

    // configuration
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic            cfg_hit;
    logic [31:0]     fw32, fh32, effw32, effh32;
    logic [EW-1:0]   eff_w;
    logic [EH-1:0]   eff_h;

    assign cfg_hit = i_cfg_valid &&
                     (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT);

    assign fw32   = 32'(r_frame_width);
    assign fh32   = 32'(r_frame_height);
    assign effw32 = (fw32 == 32'd0) ? 32'd1 : (fw32 > MAX_WIDTH) ? 32'(MAX_WIDTH) : fw32;
    assign effh32 = (fh32 == 32'd0) ? 32'd1 : (fh32 > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : fh32;
    assign eff_w  = effw32[EW-1:0];
    assign eff_h  = effh32[EH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // stage 1: accept, gray, line buffer read
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          acc, last_col, last_row;
    logic [15:0]   gray_sum;

    logic          r_s1_v;
    logic [CW-1:0] r_s1_c;
    logic [RW-1:0] r_s1_r;
    logic [7:0]    r_s1_gray;
    logic          r_s1_last_col, r_s1_last_row;
    logic          s2_fire;

    assign o_ready  = !r_s1_v || i_q_ready;
    assign acc      = i_valid && o_ready;
    assign s2_fire  = r_s1_v && i_q_ready;
    assign last_col = (EW'(r_col) + EW'(1)) == eff_w;
    assign last_row = (EH'(r_row) + EH'(1)) == eff_h;
    assign gray_sum = 16'(i_blue) * 16'(GRAY_KB) + 16'(i_green) * 16'(GRAY_KG)
                    + 16'(i_red) * 16'(GRAY_KR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            if (cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
            end else if (acc) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (acc) begin
                r_s1_v <= 1'b1;
            end else if (s2_fire) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_c        <= r_col;
            r_s1_r        <= r_row;
            r_s1_gray     <= gray_sum[GRAY_SHIFT +: 8];
            r_s1_last_col <= last_col;
            r_s1_last_row <= last_row;
        end
    end

    // line buffers: read on accept, written back when the word leaves stage 2
    logic [7:0] r_upper  [MAX_WIDTH];
    logic [7:0] r_middle [MAX_WIDTH];
    logic [7:0] r_up_q, r_mid_q;
    logic [7:0] top, mid;

    assign top = (r_s1_r >= RW'(2)) ? r_up_q  : 8'd0;
    assign mid = (r_s1_r != '0)     ? r_mid_q : 8'd0;

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_upper[r_s1_c] <= mid;
        end
        if (acc) begin
            r_up_q <= r_upper[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_middle[r_s1_c] <= r_s1_gray;
        end
        if (acc) begin
            r_mid_q <= r_middle[r_col];
        end
    end

    // stage 2: window, gradients, classification
    logic [7:0] r_win [6];   // cols c-2 then c-1, rows r-2..r each
    logic [9:0] sum_l, sum_r, sum_t, sum_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_win[i] <= 8'd0;
        end else if (s2_fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r_s1_gray;
        end
    end

    assign sum_r = 10'(top) + 10'({mid, 1'b0}) + 10'(r_s1_gray);
    assign sum_l = 10'(r_win[0]) + 10'({r_win[1], 1'b0}) + 10'(r_win[2]);
    assign sum_t = 10'(r_win[0]) + 10'({r_win[3], 1'b0}) + 10'(top);
    assign sum_b = 10'(r_win[2]) + 10'({r_win[5], 1'b0}) + 10'(r_s1_gray);

    assign o_gx = $signed(GRAD_W'(sum_r)) - $signed(GRAD_W'(sum_l));
    assign o_gy = $signed(GRAD_W'(sum_t)) - $signed(GRAD_W'(sum_b));

    always_comb begin
        o_ctl.centre   = (r_s1_r != '0) && (r_s1_c != '0);
        o_ctl.rcol     = (r_s1_r != '0) && r_s1_last_col;
        o_ctl.lrow     = r_s1_last_row;
        o_ctl.last_col = r_s1_last_col;
        o_ctl.is_edge  = (r_s1_c >= CW'(2)) && (r_s1_r >= RW'(2));
    end

    // pixels that cause no result only update the window and buffers
    assign o_push = s2_fire && (o_ctl.centre || o_ctl.rcol || o_ctl.lrow);
    assign o_col  = r_s1_c;
    assign o_row  = r_s1_r;

endmodule

// ===== rtl/sobel_back.sv =====
// ----------------------------------------------------------------------------
// sobel_back
// Result sequencer: turns each queued word into one to three results,
// forms |gx|+|gy| with saturation and drives the output register.
// ----------------------------------------------------------------------------
module sobel_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    output logic                                o_q_pop,
    input  sobel_pkg::t_emit_ctl                i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]        i_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0]       i_row,
    input  logic signed [sobel_pkg::GRAD_W-1:0] i_gx,
    input  logic signed [sobel_pkg::GRAD_W-1:0] i_gy,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_out_column,
    output logic [$clog2(MAX_HEIGHT)-1:0]       o_out_row,
    output logic [7:0]                          o_edge_res,
    output logic                                o_frame_last
);
    import sobel_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // pending mask: bit 0 centre, bit 1 right column, bit 2 last row
    logic [2:0]               r_pend;
    logic [CW-1:0]            r_c;
    logic [RW-1:0]            r_r;
    logic                     r_is_edge, r_last_col;
    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic                     r_o_valid;

    logic       out_free, emit;
    logic [2:0] pend_after;

    assign out_free   = !r_o_valid || i_ready;
    assign emit       = (r_pend != 3'b000) && out_free;
    assign pend_after = emit ? (r_pend & (r_pend - 3'd1)) : r_pend;
    assign o_q_pop    = i_q_valid && (pend_after == 3'b000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 3'b000;
            r_o_valid <= 1'b0;
        end else begin
            r_pend <= o_q_pop ? {i_ctl.lrow, i_ctl.rcol, i_ctl.centre} : pend_after;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_c        <= i_col;
            r_r        <= i_row;
            r_is_edge  <= i_ctl.is_edge;
            r_last_col <= i_ctl.last_col;
            r_gx       <= i_gx;
            r_gy       <= i_gy;
        end
    end

    // L1 magnitude
    logic [GRAD_W-1:0] ax, ay;
    logic [GRAD_W:0]   mag;
    logic [7:0]        edge_val;

    assign ax       = r_gx[GRAD_W-1] ? GRAD_W'(-r_gx) : GRAD_W'(r_gx);
    assign ay       = r_gy[GRAD_W-1] ? GRAD_W'(-r_gy) : GRAD_W'(r_gy);
    assign mag      = (GRAD_W + 1)'(ax) + (GRAD_W + 1)'(ay);
    assign edge_val = (mag > (GRAD_W + 1)'(EDGE_MAX)) ? EDGE_MAX : mag[7:0];

    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_pend[0]) begin
                o_out_column <= r_c - CW'(1);
                o_out_row    <= r_r - RW'(1);
                o_edge_res   <= r_is_edge ? edge_val : 8'd0;
                o_frame_last <= 1'b0;
            end else if (r_pend[1]) begin
                o_out_column <= r_c;
                o_out_row    <= r_r - RW'(1);
                o_edge_res   <= 8'd0;
                o_frame_last <= 1'b0;
            end else begin
                o_out_column <= r_c;
                o_out_row    <= r_r;
                o_edge_res   <= 8'd0;
                o_frame_last <= r_last_col;
            end
        end
    end

    assign o_valid = r_o_valid;

endmodule

// ===== rtl/sobel_edge_magnitude.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel edge magnitude over one raster-order BGR frame.
//
// Pixels enter one per clock while each causes at most one result: the front
// end converts to gray, keeps two line buffers (one read and one write port
// each) and the 3x3 window, and queues the gradients. All results leave
// through one output register at one word per clock while the receiver is
// ready. A pixel yields at most one result in the body of the frame and two
// at the end of each row from the second row on; in the last row it yields
// two, one in the first column and three in the last. A single-row frame
// yields one per pixel. Line buffers need no clearing: an entry is only read
// after it is written in the same frame. Width or height writes restart it.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_blue,
    input  logic [7:0]                       i_green,
    input  logic [7:0]                       i_red,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_out_column,
    output logic [$clog2(MAX_HEIGHT)-1:0]    o_out_row,
    output logic [7:0]                       o_edge_res,
    output logic                             o_frame_last
);
    import sobel_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int QW = $bits(t_emit_ctl) + CW + RW + 2 * GRAD_W;

    t_emit_ctl                f_ctl, q_ctl;
    logic [CW-1:0]            f_col, q_col;
    logic [RW-1:0]            f_row, q_row;
    logic signed [GRAD_W-1:0] f_gx, f_gy, q_gx, q_gy;
    logic                     push, q_ready, q_valid, pop;
    logic [QW-1:0]            q_wdata, q_rdata;

    assign o_cfg_ready = 1'b1;

    sobel_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .o_push      (push),
        .i_q_ready   (q_ready),
        .o_ctl       (f_ctl),
        .o_col       (f_col),
        .o_row       (f_row),
        .o_gx        (f_gx),
        .o_gy        (f_gy)
    );

    assign q_wdata = {f_ctl, f_col, f_row, f_gx, f_gy};
    assign {q_ctl, q_col, q_row, q_gx, q_gy} = q_rdata;

    sobel_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (q_wdata),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    sobel_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (pop),
        .i_ctl        (q_ctl),
        .i_col        (q_col),
        .i_row        (q_row),
        .i_gx         (q_gx),
        .i_gy         (q_gy),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_edge_res   (o_edge_res),
        .o_frame_last (o_frame_last)
    );

endmodule

// ===== rtl/sobel_checker.sv =====
// ----------------------------------------------------------------------------
// sobel_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module sobel_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [$clog2(MAX_WIDTH)-1:0]  o_out_column,
    input logic [$clog2(MAX_HEIGHT)-1:0] o_out_row,
    input logic [7:0]                    o_edge_res,
    input logic                          o_frame_last
);

    // a stalled result word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out_column) && $stable(o_out_row)
                                && $stable(o_edge_res) && $stable(o_frame_last))
        else $error("result word changed while stalled");

    // the last word of a frame is a last-row pixel, hence zero
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_last |-> o_edge_res == 8'd0)
        else $error("frame end word carries an edge value");

    // top row and left column are border pixels
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_edge_res != 8'd0) |-> (o_out_column != '0) && (o_out_row != '0))
        else $error("edge value on the frame border");

endmodule

bind sobel_edge_magnitude sobel_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_sobel_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_out_column (o_out_column),
    .o_out_row    (o_out_row),
    .o_edge_res   (o_edge_res),
    .o_frame_last (o_frame_last)
);

// ===== bench/tb_sobel_edge_magnitude.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude
// Streams BGR frames of many sizes into the edge block and predicts every
// result word (position, saturated L1 gradient, frame-end flag) from a model
// of its own. A queue-fed driver and a monitor check the words in order,
// under random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude;
    import sobel_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 4096;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_PIXELS = 320;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic [9:0]  column;
        logic [11:0] row;
        logic [7:0]  mag;
        logic        last;
    } t_edge_word;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_blue      = '0;
    logic [7:0]            i_green     = '0;
    logic [7:0]            i_red       = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [9:0]            o_out_column;
    logic [11:0]           o_out_row;
    logic [7:0]            o_edge_res;
    logic                  o_frame_last;

    sobel_edge_magnitude #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_edge_res   (o_edge_res),
        .o_frame_last (o_frame_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // edge predictor state
    // ------------------------------------------------------------------
    logic [FW_W-1:0] cfg_width  = FRAME_WIDTH_RST;
    logic [FH_W-1:0] cfg_height = FRAME_HEIGHT_RST;
    int              line_upper [MAX_W];
    int              line_middle[MAX_W];
    int              win[6]     = '{0, 0, 0, 0, 0, 0};
    int              pos_col    = 0;
    int              pos_row    = 0;

    t_pixel     pixel_q[$];
    t_edge_word edge_expect_q[$];
    t_idle_mode idle_mode    = IDLE_NONE;
    int         mismatch_cnt = 0;
    int         px_total     = 0;
    int         hold_asked   = 0;
    int         hold_taken   = 0;
    int         hold_left    = 0;
    t_pixel     drv_px;
    t_edge_word want;

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int clamp_dim(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    task automatic expect_word(int col, int row, int mag, bit last);
        t_edge_word wd;
        wd.column = col[9:0];
        wd.row    = row[11:0];
        wd.mag    = mag[7:0];
        wd.last   = last;
        edge_expect_q.push_back(wd);
    endtask

    task automatic predict_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] rd);
        int w, h, c, r, gray, top, mid, gx, gy, mag;
        bit last_row, last_col;
        w = clamp_dim(cfg_width, MAX_W);
        h = clamp_dim(cfg_height, MAX_H);
        c = pos_col;
        r = pos_row;
        gray = (30 * int'(b) + 150 * int'(g) + 76 * int'(rd)) >> 8;
        if (c >= w || r >= h) begin
            c = 0;
            r = 0;
        end
        last_row = (r + 1 == h);
        last_col = (c + 1 == w);
        top = (r >= 2) ? line_upper[c] : 0;
        mid = (r >= 1) ? line_middle[c] : 0;

        if (r >= 1) begin
            if (c >= 1) begin
                mag = 0;
                if (c >= 2 && r >= 2) begin
                    gx  = (top + 2 * mid + gray) - (win[0] + 2 * win[1] + win[2]);
                    gy  = (win[0] + 2 * win[3] + top) - (win[2] + 2 * win[5] + gray);
                    mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
                    if (mag > 255) mag = 255;
                end
                expect_word(c - 1, r - 1, mag, 1'b0);
            end
            if (last_col)
                expect_word(c, r - 1, 0, 1'b0);
        end
        if (last_row)
            expect_word(c, r, 0, last_col);

        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = gray;
        line_upper[c]  = mid;
        line_middle[c] = gray;

        if (last_col) begin
            c = 0;
            r = last_row ? 0 : r + 1;
        end else begin
            c = c + 1;
        end
        pos_col = c;
        pos_row = r;
    endtask

    task automatic log_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // pixel driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_valid && o_ready)
            predict_pixel(i_blue, i_green, i_red);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pixel_q.size() != 0 &&
                !((idle_mode == IDLE_TX && chance(71)) ||
                  (idle_mode == IDLE_BOTH && chance(24)))) begin
                drv_px = pixel_q.pop_front();
                i_valid <= 1'b1;
                i_blue  <= drv_px.blue;
                i_green <= drv_px.green;
                i_red   <= drv_px.red;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, armed by the sequence
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= hold_taken + 1;
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (edge_expect_q.size() == 0) begin
                log_mismatch($sformatf("unexpected word col %0d row %0d mag %0d last %0b",
                                       o_out_column, o_out_row, o_edge_res, o_frame_last));
            end else begin
                want = edge_expect_q.pop_front();
                if (want.column !== o_out_column || want.row !== o_out_row ||
                    want.mag !== o_edge_res || want.last !== o_frame_last)
                    log_mismatch($sformatf(
                        "exp col %0d row %0d mag %0d last %0b, got %0d %0d %0d %0b",
                        want.column, want.row, want.mag, want.last,
                        o_out_column, o_out_row, o_edge_res, o_frame_last));
            end
        end
        i_ready <= (hold_left == 0) &&
                   !((idle_mode == IDLE_RX && chance(71)) ||
                     (idle_mode == IDLE_BOTH && chance(24)));
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    task automatic push_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] rd);
        t_pixel px;
        px.blue  = b;
        px.green = g;
        px.red   = rd;
        pixel_q.push_back(px);
        px_total++;
    endtask

    task automatic push_random(int n, bit extreme);
        repeat (n) begin
            if (extreme)
                push_pixel(8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
                           8'($urandom_range(0, 1) * 255));
            else
                push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        end
    endtask

    // settled values are read at the falling edge
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || i_valid || edge_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) begin
            cfg_width = data[FW_W-1:0];
            pos_col   = 0;
            pos_row   = 0;
        end else if (idx == CFG_FRAME_HEIGHT) begin
            cfg_height = data[FH_W-1:0];
            pos_col    = 0;
            pos_row    = 0;
        end
    endtask

    initial begin
        int w, h, n, goal, phase;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: first row of a wide frame, nothing comes out
        push_random(2, 1'b0);

        // vertical step edge, saturates the centres
        set_reg(CFG_FRAME_WIDTH, 13'd4);
        set_reg(CFG_FRAME_HEIGHT, 13'd3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
                push_pixel(c >= 2 ? 8'd255 : 8'd0, c >= 2 ? 8'd255 : 8'd0,
                           c >= 2 ? 8'd255 : 8'd0);

        // all-or-nothing channels, unused index write mid-frame, wrap into next frame
        idle_mode = IDLE_BOTH;
        push_random(6, 1'b1);
        set_reg(CFG_IDX_SPARE_LO, 13'h1FFF);
        set_reg(CFG_IDX_SPARE_HI, 13'h0000);
        push_random(8, 1'b1);

        // one-pixel-wide and zero-sized frames: every pixel is border
        set_reg(CFG_FRAME_WIDTH, 13'd1);
        push_random(3, 1'b0);
        set_reg(CFG_FRAME_WIDTH, 13'd0);
        set_reg(CFG_FRAME_HEIGHT, 13'd0);
        push_random(2, 1'b0);

        // widest frames, a single row and then the clamped maxima
        set_reg(CFG_FRAME_WIDTH, 13'd1024);
        set_reg(CFG_FRAME_HEIGHT, 13'd1);
        push_random(3, 1'b0);
        set_reg(CFG_FRAME_WIDTH, 13'h07FF);
        set_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        push_random(2, 1'b0);
        set_reg(CFG_FRAME_HEIGHT, 13'd4096);
        push_random(2, 1'b0);

        // random frames, mostly whole ones, some cut short by the next write
        goal  = px_total + RANDOM_PIXELS;
        phase = 0;
        while (px_total < goal) begin
            w = chance(85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
            h = $urandom_range(1, 6);
            if (chance(5)) w = 0;
            if (chance(5)) h = 0;
            set_reg(CFG_FRAME_WIDTH, {2'($urandom_range(0, 3)), 11'(w)});
            set_reg(CFG_FRAME_HEIGHT, 13'(h));
            w = clamp_dim(w, MAX_W);
            h = clamp_dim(h, MAX_H);
            n = w * h * $urandom_range(1, 2);
            if (chance(50)) n += $urandom_range(1, w * h);
            if (n > 80) n = 80;
            idle_mode = t_idle_mode'(phase % 4);
            if (phase == 2) begin
                // receiver holds off while pixels keep coming
                idle_mode = IDLE_NONE;
                hold_asked++;
                if (n < 48) n = 48;
            end
            push_random(n, chance(20));
            wait_idle();
            phase++;
        end

        wait_idle();
        if (mismatch_cnt == 0)
            $display("tb_sobel_edge_magnitude: clean");
        else
            $display("tb_sobel_edge_magnitude: errors");
        $finish;
    end

    initial begin
        #400000;
        $display("tb_sobel_edge_magnitude: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sobel_pkg.sv
rtl/sobel_fifo.sv
rtl/sobel_front.sv
rtl/sobel_back.sv
rtl/sobel_edge_magnitude.sv
rtl/sobel_checker.sv
bench/tb_sobel_edge_magnitude.sv
